// ===== sv/ptts_pkg.sv =====
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and constants for the periodic task tick scheduler: command
// codes, transaction payloads, the table walk state and the per-slot records.
// ----------------------------------------------------------------------------
package ptts_pkg;

  // Table geometry
  localparam int TASK_SLOTS = 8;
  localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int FIRED_W    = 8;
  localparam int CNT_W      = 16;

  // Command codes
  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_CREATE  = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_SUSPEND = 3'd3,
    CMD_RESUME  = 3'd4
  } cmd_t;

  // Result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Input transaction
  typedef struct packed {
    logic [2:0]       cmd;
    logic [2:0]       slot;
    logic [CNT_W-1:0] period;
    logic [CNT_W-1:0] first_delay;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic               status;
    logic [FIRED_W-1:0] fired_mask;
  } out_item_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_WALK,
    ST_RESULT
  } state_t;

  // One table entry as seen by the tick unit
  typedef struct packed {
    logic             present;
    logic             active;
    logic [CNT_W-1:0] period;
    logic [CNT_W-1:0] count;
  } slot_entry_t;

  // Tick unit verdict for one entry
  typedef struct packed {
    logic             fire;
    logic             wr;
    logic [CNT_W-1:0] count;
  } slot_upd_t;

endpackage

// ===== sv/periodic_task_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Task slot table with tick, create, delete, suspend and resume commands.
// A tick walks the table one slot per cycle through a shared countdown unit.
// ----------------------------------------------------------------------------
// Sequencing: a tick walks every slot in ST_WALK, other commands go through
//   ST_CMD; both then pass ST_RESULT into the output register.
// Flow: one transaction at a time; a tick holds in_stall for the whole slot
//   walk through the single countdown unit, and ST_RESULT waits on out_stall.
// Reset: synchronous active-low rst_n empties the table and drops out_valid.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler
  import ptts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

  state_t           state_r, state_nxt;
  in_item_t         item_r, item_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  out_item_t        res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             present_r [TASK_SLOTS];
  logic             active_r  [TASK_SLOTS];
  logic [CNT_W-1:0] period_r  [TASK_SLOTS];
  logic [CNT_W-1:0] count_r   [TASK_SLOTS];

  // Table write port
  logic             flag_wr;
  logic             present_wr_en, present_wr_val;
  logic             active_wr_en, active_wr_val;
  logic             count_wr_en, period_wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [CNT_W-1:0] wr_count;

  logic             in_range;
  logic [IDX_W-1:0] cmd_idx;
  slot_entry_t      entry;
  slot_upd_t        upd;

  assign in_range = (int'(item_r.slot) < TASK_SLOTS);
  assign cmd_idx  = IDX_W'(item_r.slot);

  // Entry under the walk pointer
  assign entry.present = present_r[idx_r];
  assign entry.active  = active_r[idx_r];
  assign entry.period  = period_r[idx_r];
  assign entry.count   = count_r[idx_r];

  ptts_tick_unit u_tick (
    .entry (entry),
    .upd   (upd)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer state and transaction registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    idx_r      <= idx_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Slot table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        present_r[i] <= 1'b0;
        active_r[i]  <= 1'b0;
        period_r[i]  <= '0;
        count_r[i]   <= '0;
      end
    end else begin
      if (flag_wr && present_wr_en) present_r[wr_idx] <= present_wr_val;
      if (flag_wr && active_wr_en)  active_r[wr_idx]  <= active_wr_val;
      if (period_wr_en)             period_r[wr_idx]  <= item_r.period;
      if (count_wr_en)              count_r[wr_idx]   <= wr_count;
    end
  end

  // Next state, table updates and result
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    idx_nxt        = idx_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    flag_wr        = 1'b0;
    present_wr_en  = 1'b0;
    present_wr_val = 1'b0;
    active_wr_en   = 1'b0;
    active_wr_val  = 1'b0;
    count_wr_en    = 1'b0;
    period_wr_en   = 1'b0;
    wr_idx         = cmd_idx;
    wr_count       = item_r.first_delay;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          idx_nxt  = '0;
          res_nxt  = '{status: STATUS_OK, fired_mask: '0};
          state_nxt = (in_data.cmd == CMD_TICK) ? ST_WALK : ST_CMD;
        end
      end

      ST_CMD: begin
        state_nxt = ST_RESULT;
        case (item_r.cmd)
          CMD_CREATE: begin
            if (!in_range || present_r[cmd_idx]) begin
              res_nxt.status = STATUS_ERR;
            end else begin
              flag_wr        = 1'b1;
              present_wr_en  = 1'b1;
              present_wr_val = 1'b1;
              active_wr_en   = 1'b1;
              active_wr_val  = 1'b1;
              period_wr_en   = 1'b1;
              count_wr_en    = 1'b1;
            end
          end
          CMD_DELETE: begin
            flag_wr        = in_range;
            present_wr_en  = 1'b1;
            present_wr_val = 1'b0;
          end
          CMD_SUSPEND: begin
            flag_wr       = in_range;
            active_wr_en  = 1'b1;
            active_wr_val = 1'b0;
          end
          CMD_RESUME: begin
            flag_wr       = in_range;
            active_wr_en  = 1'b1;
            active_wr_val = 1'b1;
          end
          default: ;
        endcase
      end

      // One slot per cycle, in ascending slot order
      ST_WALK: begin
        wr_idx             = idx_r;
        wr_count           = upd.count;
        count_wr_en        = upd.wr;
        res_nxt.fired_mask = res_r.fired_mask | (FIRED_W'(upd.fire) << idx_r);
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_RESULT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      // Hand the result to the output register once it is free
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/ptts_tick_unit.sv =====
// ----------------------------------------------------------------------------
// ptts_tick_unit
// Shared countdown unit: decides for one slot per cycle whether it fires and
// what its countdown becomes (reload with period - 1, or decrement).
// ----------------------------------------------------------------------------
module ptts_tick_unit
  import ptts_pkg::*;
(
  input  slot_entry_t entry,
  output slot_upd_t   upd
);

  logic cnt_zero;

  assign cnt_zero = (entry.count == '0);

  // Fire and reload, or count down; inactive slots, and active slots at zero that are not present, are left alone
  always_comb begin
    upd.fire  = 1'b0;
    upd.wr    = 1'b0;
    upd.count = entry.count - CNT_W'(1);
    if (entry.active) begin
      if (entry.present && cnt_zero) begin
        upd.fire  = 1'b1;
        upd.wr    = 1'b1;
        upd.count = entry.period - CNT_W'(1);
      end else if (!cnt_zero) begin
        upd.wr = 1'b1;
      end
    end
  end

endmodule

// ===== sv/ptts_checker.sv =====
// ----------------------------------------------------------------------------
// ptts_checker
// Port-level checks for the periodic task tick scheduler, bound to the top.
// ----------------------------------------------------------------------------
module ptts_checker
  import ptts_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One transaction in flight: stall rises right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a transaction is in progress");

  // An error result never carries fired slots
  a_err_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STATUS_ERR) |-> (out_data.fired_mask == '0))
    else $error("error status with nonzero fired mask");

  // After an accept, a result passes ST_CMD or ST_WALK and then ST_RESULT before out_valid rises
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after accept");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (.*);
